// File: rtl/ucv_pkg.sv
// Shared types and constants for the UTF-8 character validator.
// Used by the front classifier, the result queue, the back emitter and the top level.
// No dependencies.
`default_nettype none

package ucv_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [15:0] SURR_MASK = 16'hf800;
  localparam logic [15:0] SURR_BASE = 16'hd800;
  localparam logic [15:0] NONCHAR_LO = 16'hfdd0;
  localparam logic [15:0] NONCHAR_HI = 16'hfdef;
  localparam logic [15:0] END_MASK = 16'hfffe;

  typedef enum logic [2:0] {
    ST_OK   = 3'd0,
    ST_CTRL = 3'd1,
    ST_LEAD = 3'd2,
    ST_CONT = 3'd3,
    ST_EXCL = 3'd4
  } status_t;

  // One queue entry describes every result caused by one request.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    status_t         status;
  } ucv_cmd_t;

endpackage

`default_nettype wire

// File: rtl/ucv_front.sv
// Front end of the UTF-8 character validator: accepts bytes, assembles characters
// and classifies them into queue entries. Depends on ucv_pkg.
`default_nettype none

module ucv_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      in_byte,
  input  wire logic            q_full,
  output logic                 push,
  output ucv_pkg::ucv_cmd_t    push_cmd
);
  import ucv_pkg::*;

  logic [2:0]  char_length, char_length_next;
  logic [1:0]  bytes_seen, bytes_seen_next;
  logic [7:0]  held0, held1, held2;
  logic        open_char;
  logic        take;
  logic [15:0] val3, low4;
  logic        excluded;

  assign in_ready  = !q_full;
  assign take      = in_valid && in_ready;
  assign open_char = (char_length != 3'd0);

  assign val3 = {held0[3:0], held1[5:0], in_byte[5:0]};
  assign low4 = {held1[3:0], held2[5:0], in_byte[5:0]};

  always_comb begin
    excluded = 1'b0;
    if (char_length == 3'd3) begin
      excluded = ((val3 & SURR_MASK) == SURR_BASE) ||
                 (val3 >= NONCHAR_LO && val3 <= NONCHAR_HI) ||
                 ((val3 & END_MASK) == END_MASK);
    end else if (char_length == 3'd4) begin
      excluded = ((low4 & END_MASK) == END_MASK);
    end
  end

  always_comb begin
    char_length_next  = char_length;
    bytes_seen_next   = bytes_seen;
    push              = 1'b0;
    push_cmd.bytes    = {4{in_byte}};
    push_cmd.last_idx = 2'd0;
    push_cmd.status   = ST_OK;
    if (take) begin
      if (!open_char) begin
        if (!in_byte[7]) begin
          push = 1'b1;
          if (in_byte < CH_SPACE && in_byte != CH_TAB && in_byte != CH_LF &&
              in_byte != CH_CR) begin
            push_cmd.status = ST_CTRL;
          end
        end else if (in_byte < 8'hc0 || in_byte >= 8'hf8) begin
          push            = 1'b1;
          push_cmd.status = ST_LEAD;
        end else begin
          bytes_seen_next = 2'd1;
          if (in_byte < 8'he0) begin
            char_length_next = 3'd2;
          end else if (in_byte < 8'hf0) begin
            char_length_next = 3'd3;
          end else begin
            char_length_next = 3'd4;
          end
        end
      end else if (in_byte[7:6] != 2'b10) begin
        push             = 1'b1;
        push_cmd.status  = ST_CONT;
        char_length_next = 3'd0;
        bytes_seen_next  = 2'd0;
      end else if ({1'b0, bytes_seen} + 3'd1 < char_length) begin
        bytes_seen_next = bytes_seen + 2'd1;
      end else begin
        push             = 1'b1;
        char_length_next = 3'd0;
        bytes_seen_next  = 2'd0;
        if (excluded) begin
          push_cmd.status = ST_EXCL;
        end else begin
          push_cmd.bytes[0] = held0;
          push_cmd.bytes[1] = (char_length == 3'd2) ? in_byte : held1;
          push_cmd.bytes[2] = (char_length == 3'd3) ? in_byte : held2;
          push_cmd.bytes[3] = in_byte;
          push_cmd.last_idx = 2'(char_length - 3'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_length <= 3'd0;
      bytes_seen  <= 2'd0;
    end else begin
      char_length <= char_length_next;
      bytes_seen  <= bytes_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (!open_char) begin
        held0 <= in_byte;
      end else if (bytes_seen == 2'd1) begin
        held1 <= in_byte;
      end else begin
        held2 <= in_byte;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/ucv_queue.sv
// Short queue of classified entries between the front and back ends of the
// UTF-8 character validator. Depends on ucv_pkg.
`default_nettype none

module ucv_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire ucv_pkg::ucv_cmd_t push_cmd,
  input  wire logic              pop,
  output logic                   full,
  output logic                   not_empty,
  output ucv_pkg::ucv_cmd_t      head
);
  import ucv_pkg::*;

  ucv_cmd_t            entries [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ucv_back.sv
// Back end of the UTF-8 character validator: walks each queue entry and
// emits its results one per cycle while the receiver is ready, through an output register. Depends on ucv_pkg.
`default_nettype none

module ucv_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_not_empty,
  input  wire ucv_pkg::ucv_cmd_t head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_byte,
  output logic [2:0]             out_status,
  output logic                   out_last
);
  import ucv_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       at_last;

  assign load    = q_not_empty && (!out_valid || out_ready);
  assign at_last = (idx == head.last_idx);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_last ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte   <= head.bytes[idx];
      out_status <= head.status;
      out_last   <= at_last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/utf8_char_validator_unit.sv
// Top level of the UTF-8 character validator for XML text.
// Instantiates ucv_front, ucv_queue and ucv_back; depends on ucv_pkg.
//
// Usage: one byte of UTF-8 text enters per request on the s_ channel. Results
// leave on the m_ channel: the byte in tdata, the status in tuser (0 ok, 1 bad
// control byte, 2 bad lead byte, 3 bad continuation, 4 excluded code point) and
// tlast on the final result caused by an input byte.
// A complete character is released as its bytes, with tlast on the final one; an
// error yields a single result carrying the offending byte, and the next byte is
// taken as a lead byte. Bytes inside an open character yield no result.
// Path: a byte that completes a result is written into the queue, and the emitter
// then moves it from the queue head into the output register that drives m_tvalid.
// Throughput: one input byte per cycle while the queue is not full, and one result per
// cycle while the receiver is ready; a four-entry queue between classifier and emitter
// absorbs the bursts of a multi-byte character. When the receiver stalls, the output
// register holds its result and s_tready falls only once the queue is full.
// Reset clears the open character, the queue and the valid flag of the output register.
`default_nettype none

module utf8_char_validator_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic [2:0]      m_tuser,   // [2:0] status
  output logic            m_tlast
);
  import ucv_pkg::*;

  ucv_cmd_t push_cmd;
  ucv_cmd_t head;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_not_empty;

  ucv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  ucv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  ucv_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_byte    (m_tdata),
    .out_status  (m_tuser),
    .out_last    (m_tlast)
  );

endmodule

`default_nettype wire
